[rtl/dsn_pkg.sv]
// ----------------------------------------------------------------------------
// dsn_pkg
// Shared types and constants of the distributed semaphore node.
// ----------------------------------------------------------------------------
package dsn_pkg;

  localparam int unsigned NUM_NODES   = 5;
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned NUM_SEMS    = 5;
  localparam int unsigned QAW         = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW         = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NIW         = $clog2(NUM_NODES);

  localparam logic [2:0] CMD_ACK   = 3'd0;
  localparam logic [2:0] CMD_P     = 3'd1;
  localparam logic [2:0] CMD_V     = 3'd2;
  localparam logic [2:0] CMD_LOC_P = 3'd3;
  localparam logic [2:0] CMD_LOC_V = 3'd4;

  localparam logic [1:0] OUT_ACK = 2'd0;
  localparam logic [1:0] OUT_P   = 2'd1;
  localparam logic [1:0] OUT_V   = 2'd2;

  typedef struct packed {
    logic [31:0] clock;
    logic [2:0]  sender;
    logic        is_v;
    logic [2:0]  sem;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  typedef struct packed {
    logic        send_msg;
    logic [1:0]  out_cmd;
    logic [2:0]  out_sender;
    logic [31:0] out_clock;
    logic [2:0]  out_sem;
    logic [6:0]  grants;
    logic        queue_overflow;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MIN, ST_INS_RD, ST_INS_EV, ST_SW_RD, ST_SW_EV,
    ST_CP_RD, ST_CP_EV, ST_FIN
  } state_e;

endpackage

[rtl/dsn_ram.sv]
// ----------------------------------------------------------------------------
// dsn_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module dsn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

[rtl/dsn_ctrl.sv]
// ----------------------------------------------------------------------------
// dsn_ctrl
// Sequencer: clock update, ordered insert, acknowledge sweeps and compaction.
// ----------------------------------------------------------------------------
module dsn_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       own_node_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       cmd_i,
  input  logic [2:0]       sender_i,
  input  logic [31:0]      clock_i,
  input  logic [2:0]       sem_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output dsn_pkg::result_t res_o
);
  import dsn_pkg::*;

  state_e state_q, state_d;
  logic [31:0] lclk_q, lclk_d;
  logic [31:0] ack_q [NUM_NODES];
  logic [7:0]  cnt_q [NUM_SEMS];
  logic [QUEUE_DEPTH-1:0] done_q;
  logic [QCW-1:0] fill_q, k_q, j_q;
  logic        pass_q;
  entry_t      new_q;
  logic [31:0] lim_q;
  logic [6:0]  grants_q;
  result_t     res_q;

  logic        we;
  logic [QAW-1:0] addr;
  entry_t      wdata, rdata;
  logic [EW-1:0] rraw;
  logic [31:0] lmax;
  logic        precedes;

  dsn_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rraw)
  );

  assign rdata       = entry_t'(rraw);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_FIN);
  assign res_o       = res_q;
  assign lmax        = ((clock_i > lclk_q) ? clock_i : lclk_q) + 32'd1;
  assign precedes    = (rdata.clock != new_q.clock) ? (rdata.clock < new_q.clock)
                                                    : (rdata.sender <= new_q.sender);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_ACK) begin
            state_d = ST_MIN;
          end else if ((cmd_i == CMD_P || cmd_i == CMD_V) && sem_i < 3'(NUM_SEMS)
                       && fill_q != QCW'(QUEUE_DEPTH)) begin
            state_d = ST_INS_RD;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_MIN:    if (k_q == QCW'(NUM_NODES - 1)) state_d = ST_SW_RD;
      ST_INS_RD: state_d = (k_q == '0) ? ST_FIN : ST_INS_EV;
      ST_INS_EV: state_d = precedes ? ST_FIN : ST_INS_RD;
      ST_SW_RD: begin
        if (k_q < fill_q) state_d = ST_SW_EV;
        else if (pass_q) state_d = ST_CP_RD;
      end
      ST_SW_EV: begin
        if (rdata.clock < lim_q) state_d = ST_SW_RD;
        else if (pass_q) state_d = ST_CP_RD;
        else state_d = ST_SW_RD;
      end
      ST_CP_RD:  state_d = (k_q < fill_q) ? ST_CP_EV : ST_FIN;
      ST_CP_EV:  state_d = ST_CP_RD;
      ST_FIN:    if (res_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    addr  = k_q[QAW-1:0];
    wdata = rdata;
    lclk_d = lclk_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) lclk_d = (cmd_i <= CMD_LOC_V) && (cmd_i != CMD_ACK)
                                       ? lmax + 32'd1 : lmax;
      ST_INS_RD: begin
        if (k_q == '0) begin
          we = 1'b1; wdata = new_q;
        end else begin
          addr = QAW'(k_q - QCW'(1));
        end
      end
      ST_INS_EV: begin
        we = 1'b1;
        wdata = precedes ? new_q : rdata;
      end
      ST_CP_EV: begin
        we = !done_q[k_q[QAW-1:0]];
        addr = j_q[QAW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      lclk_q   <= '0;
      fill_q   <= '0;
      done_q   <= '0;
      k_q      <= '0;
      j_q      <= '0;
      pass_q   <= 1'b0;
      grants_q <= '0;
      for (int i = 0; i < NUM_NODES; i++) ack_q[i] <= '0;
      for (int i = 0; i < NUM_SEMS; i++) cnt_q[i] <= 8'd1;
    end else begin
      state_q <= state_d;
      lclk_q  <= lclk_d;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            new_q <= '{clock: clock_i, sender: sender_i, is_v: cmd_i == CMD_V, sem: sem_i};
            lim_q <= clock_i;
            k_q <= (cmd_i == CMD_P || cmd_i == CMD_V) ? fill_q : '0;
            pass_q <= 1'b0;
            grants_q <= '0;
            if (cmd_i == CMD_LOC_P || cmd_i == CMD_LOC_V) begin
              res_q <= '{send_msg: 1'b1,
                         out_cmd: (cmd_i == CMD_LOC_P) ? OUT_P : OUT_V,
                         out_sender: sender_i, out_clock: lmax, out_sem: sem_i,
                         grants: 7'd0, queue_overflow: 1'b0};
            end else if (cmd_i == CMD_P || cmd_i == CMD_V) begin
              res_q <= '{send_msg: 1'b1, out_cmd: OUT_ACK, out_sender: own_node_i,
                         out_clock: lmax, out_sem: 3'd0, grants: 7'd0,
                         queue_overflow: (sem_i < 3'(NUM_SEMS))
                                         && (fill_q == QCW'(QUEUE_DEPTH))};
            end else begin
              res_q <= '0;
            end
            if (cmd_i == CMD_ACK && sender_i >= 3'd1
                && {1'b0, sender_i} <= 4'(NUM_NODES)) begin
              ack_q[NIW'(sender_i - 3'd1)] <= clock_i;
            end
          end
        end
        ST_MIN: begin
          if (ack_q[k_q[NIW-1:0]] < lim_q) lim_q <= ack_q[k_q[NIW-1:0]];
          k_q <= (k_q == QCW'(NUM_NODES - 1)) ? '0 : k_q + QCW'(1);
        end
        ST_INS_RD: if (k_q == '0) fill_q <= fill_q + QCW'(1);
        ST_INS_EV: begin
          if (precedes) fill_q <= fill_q + QCW'(1);
          else k_q <= k_q - QCW'(1);
        end
        ST_SW_RD: begin
          if (!(k_q < fill_q)) begin
            pass_q <= 1'b1; k_q <= '0; j_q <= '0;
          end
        end
        ST_SW_EV: begin
          if (rdata.clock < lim_q) begin
            k_q <= k_q + QCW'(1);
            if (rdata.sem < 3'(NUM_SEMS)) begin
              if (!pass_q && rdata.is_v) begin
                done_q[k_q[QAW-1:0]] <= 1'b1;
                if (cnt_q[rdata.sem] != 8'd255) cnt_q[rdata.sem] <= cnt_q[rdata.sem] + 8'd1;
              end else if (pass_q && !rdata.is_v && cnt_q[rdata.sem] != 8'd0) begin
                done_q[k_q[QAW-1:0]] <= 1'b1;
                cnt_q[rdata.sem] <= cnt_q[rdata.sem] - 8'd1;
                if (rdata.sender == own_node_i && grants_q != 7'd127) begin
                  grants_q <= grants_q + 7'd1;
                end
              end
            end
          end else begin
            pass_q <= 1'b1; k_q <= '0; j_q <= '0;
          end
        end
        ST_CP_RD: begin
          if (!(k_q < fill_q)) begin
            fill_q <= j_q;
            done_q <= '0;
            res_q.grants <= grants_q;
          end
        end
        ST_CP_EV: begin
          if (!done_q[k_q[QAW-1:0]]) j_q <= j_q + QCW'(1);
          k_q <= k_q + QCW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/distributed_semaphore_node_core.sv]
// ----------------------------------------------------------------------------
// distributed_semaphore_node_core
// Lamport-clock ordered distributed semaphore node.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Local requests, unknown commands and network
// ops that are not queued (semaphore index out of range or queue full) go
// straight to the result; a queued network P or V op first does an ordered
// insert into the single-port queue RAM; an ack first finds the oldest acked
// clock over all nodes, then runs the two apply sweeps and the compaction pass,
// each reading the queue entry by entry.
// A result waits in the output register until taken.
module distributed_semaphore_node_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,     // own_node
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i, // sender, msg_clock, sem_index, zero pad
  input  logic [2:0]  s_axis_tuser_i, // cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o, // out_sender, out_clock, out_sem, grants,
                                      // queue_overflow, zero pad
  output logic [2:0]  m_axis_tuser_o  // send_msg, out_cmd
);
  import dsn_pkg::*;

  logic [2:0] own_q;
  result_t    res, out_q;
  logic       res_valid, res_ready, out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= 3'd1;
    end else if (cfg_valid_i) begin
      own_q <= cfg_data_i;
    end
  end

  dsn_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .own_node_i(own_q),
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .cmd_i(s_axis_tuser_i), .sender_i(s_axis_tdata_i[2:0]),
    .clock_i(s_axis_tdata_i[34:3]), .sem_i(s_axis_tdata_i[37:35]),
    .res_valid_o(res_valid), .res_ready_i(res_ready), .res_o(res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = {out_q.out_cmd, out_q.send_msg};
  assign m_axis_tdata_o  = {2'b00, out_q.queue_overflow, out_q.grants, out_q.out_sem,
                            out_q.out_clock, out_q.out_sender};

endmodule

[rtl/dsn_checker.sv]
// ----------------------------------------------------------------------------
// dsn_checker
// Port-level checks of the semaphore node, bound to the top level.
// ----------------------------------------------------------------------------
module dsn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("Output beat dropped while stalled.");

  a_grant_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[44:38] != 7'd0 |-> !m_axis_tuser_o[0])
    else $error("Grants reported on a broadcast beat.");

  a_ovf_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[45] |-> m_axis_tuser_o == 3'b001)
    else $error("Overflow reported without an ack broadcast.");

  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[37:0] == 38'd0)
    else $error("Message fields set without a broadcast.");

endmodule

bind distributed_semaphore_node_core dsn_checker u_dsn_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i), .m_axis_tdata_o(m_axis_tdata_o),
  .m_axis_tuser_o(m_axis_tuser_o)
);

[dv/distributed_semaphore_node_core_test.sv]
// ----------------------------------------------------------------------------
// distributed_semaphore_node_core_test
// Drives network ops, acks and local requests into the semaphore node and
// checks every result beat against a behavioral copy of the node held in the
// testbench, over several node identities, with random gaps on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module distributed_semaphore_node_core_test;
  import dsn_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [31:0] clock;
    logic [2:0]  sender;
    logic        is_v;
    logic [2:0]  sem;
    logic        done;
  } op_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [2:0]  sender;
    logic [31:0] clock;
    logic [2:0]  sem;
    logic        typed;
    result_t     res;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic [2:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  distributed_semaphore_node_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  logic [2:0]  node_id;
  logic [31:0] lamport;
  logic [31:0] acked [NUM_NODES];
  logic [7:0]  count [NUM_SEMS];
  op_t         pending_ops [$];
  result_t     expected_beats [$];
  row_t        rows [$];

  int unsigned errors;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned drops_seen;
  int unsigned grants_seen;
  int unsigned cycles;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, expected_beats.size());
      $display("distributed_semaphore_node_core_test: FAIL");
      $finish;
    end
  end

  function automatic int unsigned apply_ready(logic [31:0] limit);
    int unsigned granted;
    op_t kept [$];
    granted = 0;
    for (int i = 0; i < pending_ops.size() && pending_ops[i].clock < limit; i++) begin
      if (pending_ops[i].is_v && pending_ops[i].sem < NUM_SEMS) begin
        pending_ops[i].done = 1'b1;
        if (count[pending_ops[i].sem] != 8'd255) count[pending_ops[i].sem]++;
      end
    end
    for (int i = 0; i < pending_ops.size() && pending_ops[i].clock < limit; i++) begin
      if (!pending_ops[i].is_v && pending_ops[i].sem < NUM_SEMS &&
          count[pending_ops[i].sem] != 8'd0) begin
        pending_ops[i].done = 1'b1;
        count[pending_ops[i].sem]--;
        if (pending_ops[i].sender == node_id && granted < 127) granted++;
      end
    end
    foreach (pending_ops[i]) if (!pending_ops[i].done) kept.push_back(pending_ops[i]);
    pending_ops = kept;
    return granted;
  endfunction

  function automatic result_t node_step(logic [2:0] cmd, logic [2:0] snd,
                                        logic [31:0] clk, logic [2:0] sem);
    result_t     r;
    op_t         e;
    int          pos;
    logic [31:0] oldest;
    r = '0;
    if (clk > lamport) lamport = clk;
    lamport = lamport + 32'd1;
    if (cmd == CMD_LOC_P || cmd == CMD_LOC_V) begin
      r.send_msg   = 1'b1;
      r.out_cmd    = (cmd == CMD_LOC_P) ? OUT_P : OUT_V;
      r.out_sender = snd;
      r.out_clock  = lamport;
      r.out_sem    = sem;
      lamport      = lamport + 32'd1;
    end else if (cmd == CMD_P || cmd == CMD_V) begin
      if (sem < NUM_SEMS) begin
        if (pending_ops.size() >= QUEUE_DEPTH) begin
          r.queue_overflow = 1'b1;
        end else begin
          e.clock = clk;
          e.sender = snd;
          e.is_v = (cmd == CMD_V);
          e.sem = sem;
          e.done = 1'b0;
          pos = 0;
          while (pos < pending_ops.size() &&
                 (pending_ops[pos].clock != clk ? pending_ops[pos].clock < clk
                                                : pending_ops[pos].sender <= snd))
            pos++;
          pending_ops.insert(pos, e);
        end
      end
      r.send_msg   = 1'b1;
      r.out_cmd    = OUT_ACK;
      r.out_sender = node_id;
      r.out_clock  = lamport;
      lamport      = lamport + 32'd1;
    end else if (cmd == CMD_ACK) begin
      oldest = clk;
      if (snd >= 1 && snd <= NUM_NODES) acked[snd - 1] = clk;
      for (int i = 0; i < NUM_NODES; i++) if (acked[i] < oldest) oldest = acked[i];
      r.grants = 7'(apply_ready(oldest));
    end
    return r;
  endfunction

  task automatic send_beat(logic [2:0] cmd, logic [2:0] snd, logic [31:0] clk,
                           logic [2:0] sem, bit typed, result_t typed_res);
    int unsigned gap;
    result_t     r;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {2'b00, sem, clk, snd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = node_step(cmd, snd, clk, sem);
    expected_beats.push_back(typed ? typed_res : r);
    beats_in++;
  endtask

  task automatic drain_and_config(logic [2:0] id);
    s_axis_tvalid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= id;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    node_id = id;
  endtask

  // Mostly well-formed traffic stamped near the current clock, so that acks
  // from all nodes keep releasing queued ops; some noise across every field.
  task automatic random_phase(int unsigned n, int unsigned noise_pct, bit v_bias,
                              int unsigned burst);
    logic [2:0]  cmd;
    logic [2:0]  snd;
    logic [31:0] clk;
    logic [2:0]  sem;
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      snd  = 3'($urandom_range(1, NUM_NODES));
      sem  = 3'($urandom_range(0, NUM_SEMS - 1));
      clk  = lamport + 32'($urandom_range(0, 3));
      if (k < burst) begin
        cmd = ($urandom_range(0, 1) != 0) ? CMD_V : CMD_P;
        clk = lamport;
      end else if (pick < noise_pct) begin
        cmd = 3'($urandom_range(0, 7));
        snd = 3'($urandom);
        sem = 3'($urandom);
        clk = ($urandom_range(0, 3) == 0) ? $urandom : lamport - 32'($urandom_range(0, 8));
      end else if (pick < 45) begin
        cmd = CMD_ACK;
      end else if (pick < 85) begin
        cmd = ($urandom_range(0, 99) < (v_bias ? 80 : 55)) ? CMD_V : CMD_P;
        if (v_bias) sem = 3'd0;
      end else begin
        cmd = ($urandom_range(0, 1) != 0) ? CMD_LOC_V : CMD_LOC_P;
      end
      send_beat(cmd, snd, clk, sem, 1'b0, '0);
    end
  endtask

  function automatic void add_row(logic [2:0] cmd, logic [2:0] snd, logic [31:0] clk,
                                  logic [2:0] sem, bit typed, result_t res);
    row_t t;
    t.cmd = cmd;
    t.sender = snd;
    t.clock = clk;
    t.sem = sem;
    t.typed = typed;
    t.res = res;
    rows.push_back(t);
  endfunction

  initial begin
    int unsigned w;
    m_axis_tready_i <= 1'b0;
    forever begin
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        w = $urandom_range(0, 6);
        if (($urandom_range(0, 3) == 0)) w = 0;
        if (w != 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (w) @(posedge clk_i);
        end
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o && !hold_req);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.send_msg       = m_axis_tuser_o[0];
      got.out_cmd        = m_axis_tuser_o[2:1];
      got.out_sender     = m_axis_tdata_o[2:0];
      got.out_clock      = m_axis_tdata_o[34:3];
      got.out_sem        = m_axis_tdata_o[37:35];
      got.grants         = m_axis_tdata_o[44:38];
      got.queue_overflow = m_axis_tdata_o[45];
      beats_out++;
      drops_seen  += got.queue_overflow;
      grants_seen += got.grants;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %p", $time, got);
      end else begin
        want = expected_beats.pop_front();
        if (got.send_msg !== want.send_msg || got.out_cmd !== want.out_cmd ||
            got.out_sender !== want.out_sender || got.out_clock !== want.out_clock ||
            got.out_sem !== want.out_sem || got.grants !== want.grants ||
            got.queue_overflow !== want.queue_overflow) begin
          errors++;
          $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
        end
      end
    end
  end

  initial begin
    result_t r;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    drops_seen = 0;
    grants_seen = 0;
    cycles = 0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 3'd1;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = CMD_ACK;
    node_id = 3'd1;
    lamport = '0;
    for (int i = 0; i < NUM_NODES; i++) acked[i] = '0;
    for (int i = 0; i < NUM_SEMS; i++) count[i] = 8'd1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    r = '0;
    r.send_msg = 1'b1;
    r.out_cmd = OUT_P;
    r.out_sender = 3'd1;
    r.out_clock = 32'd1;
    add_row(CMD_LOC_P, 3'd1, 32'd0, 3'd0, 1'b1, r);
    add_row(3'd7, 3'd0, 32'hFFFF_FFFF, 3'd7, 1'b1, '0);
    add_row(CMD_P, 3'd2, 32'd10, 3'd1, 1'b0, '0);
    add_row(CMD_P, 3'd3, 32'd10, 3'd1, 1'b0, '0);
    add_row(CMD_V, 3'd3, 32'd10, 3'd1, 1'b0, '0);
    add_row(CMD_P, 3'd1, 32'd5, 3'd0, 1'b0, '0);
    add_row(CMD_V, 3'd4, 32'd6, 3'd7, 1'b0, '0);
    add_row(CMD_LOC_V, 3'd5, 32'd0, 3'd7, 1'b0, '0);
    add_row(CMD_ACK, 3'd0, 32'd100, 3'd0, 1'b0, '0);
    add_row(CMD_ACK, 3'd7, 32'd100, 3'd0, 1'b0, '0);
    for (int s = 1; s <= NUM_NODES; s++) add_row(CMD_ACK, 3'(s), 32'd50, 3'd0, 1'b0, '0);
    add_row(CMD_ACK, 3'd2, 32'hFFFF_FFFF, 3'd0, 1'b0, '0);
    add_row(CMD_P, 3'd1, 32'hFFFF_FFFF, 3'd4, 1'b0, '0);
    add_row(3'd5, 3'd6, 32'd3, 3'd5, 1'b0, '0);
    add_row(3'd6, 3'd5, 32'd4, 3'd6, 1'b0, '0);
    add_row(CMD_ACK, 3'd1, 32'd0, 3'd0, 1'b0, '0);

    drain_and_config(3'd1);
    foreach (rows[i]) send_beat(rows[i].cmd, rows[i].sender, rows[i].clock, rows[i].sem,
                                rows[i].typed, rows[i].res);

    drain_and_config(3'd5);
    hold_req = 1'b1;
    random_phase(500, 10, 1'b0, 80);
    drain_and_config(3'd3);
    random_phase(450, 5, 1'b1, 0);
    drain_and_config(3'd5);
    random_phase(500, 25, 1'b0, 0);

    s_axis_tvalid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (expected_beats.size() != 0) errors++;
    $display("Sent %0d beats over node ids 1, 5 and 3; received %0d result beats.",
             beats_in, beats_out);
    $display("Observed %0d dropped ops and %0d granted local P ops.", drops_seen, grants_seen);
    if (errors == 0) begin
      $display("distributed_semaphore_node_core_test: PASS");
    end else begin
      $display("distributed_semaphore_node_core_test: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dsn_pkg.sv
rtl/dsn_ram.sv
rtl/dsn_ctrl.sv
rtl/distributed_semaphore_node_core.sv
rtl/dsn_checker.sv
dv/distributed_semaphore_node_core_test.sv
